[src/pist_pkg.sv]
package pist_pkg;

   localparam int CoordBits = 24;
   localparam int TolBits = 40;
   localparam int RoleBits = 3;
   // difference of two coordinates
   localparam int DiffBits = CoordBits + 1;
   // product of two differences, and the 2x2 minor
   localparam int ProdBits = 2 * DiffBits;
   localparam int MinorBits = ProdBits + 1;
   // accumulator wide enough for any 3x3 determinant or triangle sum
   localparam int AccBits = DiffBits + MinorBits + 3;

   localparam logic [RoleBits-1:0] RolePoint = 3'd0;
   localparam logic [RoleBits-1:0] RoleV2 = 3'd3;
   localparam logic [RoleBits-1:0] RoleV3 = 3'd4;

   localparam logic CsrMode = 1'b0;
   localparam logic CsrTol = 1'b1;

   typedef logic signed [CoordBits-1:0] coord_type;

   // job handed from the front to the back: a snapshot of all coordinates
   typedef struct packed {
      logic three_d;
      logic [TolBits-1:0] tol;
      coord_type [2:0] pnt;
      coord_type [11:0] vtx;
   } job_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MINOR,
      ST_TERM,
      ST_TERMH,
      ST_NEXT,
      ST_TRI,
      ST_TRIC,
      ST_DONE
   } back_state_type;

endpackage

[src/pist_front.sv]
module pist_front (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [2:0] role,
   input  pist_pkg::coord_type cx,
   input  pist_pkg::coord_type cy,
   input  pist_pkg::coord_type cz,
   input  logic three_d,
   input  logic [pist_pkg::TolBits-1:0] tol,
   output logic job_valid,
   input  logic job_ready,
   output pist_pkg::job_type job
);
   pist_pkg::coord_type [2:0] pnt_ff, pnt_in;
   pist_pkg::coord_type [11:0] vtx_ff, vtx_in;
   logic fire, trig;
   logic [3:0] vb;

   // stall only when a trigger word finds the job queue full
   assign trig = (three_d && role == pist_pkg::RoleV3) ||
                 (!three_d && role == pist_pkg::RoleV2);
   assign req_tready = !trig || job_ready;
   assign fire = req_tvalid && req_tready;

   // first store entry of the vertex: 3 * (role - 1)
   assign vb = {role - 3'd1, 1'b0} + {1'b0, role - 3'd1};

   // store coordinates by role
   always_comb begin
      pnt_in = pnt_ff;
      vtx_in = vtx_ff;
      if (fire) begin
         if (role == pist_pkg::RolePoint) begin
            pnt_in = {cz, cy, cx};
         end else if (role <= pist_pkg::RoleV3) begin
            vtx_in[vb]        = cx;
            vtx_in[vb + 4'd1] = cy;
            vtx_in[vb + 4'd2] = cz;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pnt_ff <= '0;
         vtx_ff <= '0;
      end else begin
         pnt_ff <= pnt_in;
         vtx_ff <= vtx_in;
      end
   end

   // job sees the store after this word's write
   assign job_valid = req_tvalid && trig;
   assign job.three_d = three_d;
   assign job.tol = tol;
   assign job.pnt = pnt_in;
   assign job.vtx = vtx_in;
endmodule

[src/pist_queue.sv]
module pist_queue (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  pist_pkg::job_type in_job,
   output logic out_valid,
   input  logic out_ready,
   output pist_pkg::job_type out_job
);
   // two-entry queue
   pist_pkg::job_type [1:0] mem_ff;
   logic wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic push, pop;

   assign in_ready = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_job = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= in_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule

[src/pist_back.sv]
module pist_back (
   input  logic clock,
   input  logic reset,
   input  logic job_valid,
   output logic job_ready,
   input  pist_pkg::job_type job,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [7:0] rsp_tdata
);
   localparam int DB = pist_pkg::DiffBits;
   localparam int MB = pist_pkg::MinorBits;
   localparam int AB = pist_pkg::AccBits;
   // the minor enters the term multiplier as a low and a high half
   localparam int LB = (MB + 1) / 2;

   pist_pkg::back_state_type st_ff, st_in;
   pist_pkg::job_type job_ff;
   logic [2:0] k_ff, k_in;     // determinant index 0..4
   logic [1:0] j_ff, j_in;     // cofactor column 0..2
   logic signed [MB-1:0] minor_ff;
   logic signed [AB-1:0] acc_ff;
   logic ge_ff, le_ff, res_ff;
   logic signed [DB-1:0] a [3], b [3], c [3];
   pist_pkg::coord_type [3:0][2:0] rows;
   logic signed [DB-1:0] m0, m1, m2, m3, aj;
   logic signed [MB-1:0] minor_c;
   logic signed [DB+LB:0] plo;
   logic signed [DB+MB-LB-1:0] phi;
   logic signed [AB-1:0] term, acc_nx, det, tol_w;
   logic signed [AB-1:0] ns_c, nt_c, den_c, ns_ff, nt_ff, den_ff;
   logic signed [AB-1:0] dn, nsn, ntn;
   logic tri_ok;

   // rows of the current determinant, point substituted at row k-1
   always_comb begin
      for (int v = 0; v < 4; v++) begin
         for (int i = 0; i < 3; i++) begin
            rows[v][i] = (k_ff == 3'(v + 1)) ? job_ff.pnt[i] : job_ff.vtx[3*v+i];
         end
      end
      for (int i = 0; i < 3; i++) begin
         a[i] = DB'(rows[1][i]) - DB'(rows[0][i]);
         b[i] = DB'(rows[2][i]) - DB'(rows[0][i]);
         c[i] = DB'(rows[3][i]) - DB'(rows[0][i]);
      end
   end

   // operand select for the shared minor and term multipliers
   always_comb begin
      m0 = '0; m1 = '0; m2 = '0; m3 = '0; aj = '0;
      case (j_ff)
         2'd0: begin m0 = b[1]; m1 = c[2]; m2 = b[2]; m3 = c[1]; aj = a[0]; end
         2'd1: begin m0 = b[0]; m1 = c[2]; m2 = b[2]; m3 = c[0]; aj = a[1]; end
         default: begin m0 = b[0]; m1 = c[1]; m2 = b[1]; m3 = c[0]; aj = a[2]; end
      endcase
      minor_c = MB'(m0 * m1) - MB'(m2 * m3);
      // term in two steps: low half (unsigned) then high half (signed)
      plo = aj * $signed({1'b0, minor_ff[LB-1:0]});
      phi = aj * $signed(minor_ff[MB-1:LB]);
      term = (st_ff == pist_pkg::ST_TERMH) ? (AB'(phi) <<< LB) : AB'(plo);
      acc_nx = (j_ff == 2'd1) ? acc_ff - term : acc_ff + term;
      det = -acc_nx;
      tol_w = AB'({1'b0, job_ff.tol});
   end

   // triangle numerators and denominator (narrow 2x2 only)
   always_comb begin
      logic signed [DB-1:0] x01, y01, x02, y02, x0p, y0p;
      x01 = DB'(job_ff.vtx[0]) - DB'(job_ff.vtx[3]);
      y01 = DB'(job_ff.vtx[1]) - DB'(job_ff.vtx[4]);
      x02 = DB'(job_ff.vtx[0]) - DB'(job_ff.vtx[6]);
      y02 = DB'(job_ff.vtx[1]) - DB'(job_ff.vtx[7]);
      x0p = DB'(job_ff.vtx[0]) - DB'(job_ff.pnt[0]);
      y0p = DB'(job_ff.vtx[1]) - DB'(job_ff.pnt[1]);
      ns_c = AB'(x0p * y02) - AB'(x02 * y0p);
      nt_c = AB'(x01 * y0p) - AB'(x0p * y01);
      den_c = AB'(x01 * y02) - AB'(x02 * y01);
   end

   // triangle bounds check on the registered sums
   always_comb begin
      nsn = den_ff[AB-1] ? -ns_ff : ns_ff;
      ntn = den_ff[AB-1] ? -nt_ff : nt_ff;
      dn = den_ff[AB-1] ? -den_ff : den_ff;
      tri_ok = (den_ff != '0) && !nsn[AB-1] && (nsn <= dn) && !ntn[AB-1] &&
               (ntn <= dn) && (nsn + ntn <= dn);
   end

   // next state
   always_comb begin
      st_in = st_ff;
      k_in = k_ff;
      j_in = j_ff;
      unique case (st_ff)
         pist_pkg::ST_IDLE: if (job_valid) begin
            st_in = job.three_d ? pist_pkg::ST_MINOR : pist_pkg::ST_TRI;
            k_in = '0;
            j_in = '0;
         end
         pist_pkg::ST_MINOR: st_in = pist_pkg::ST_TERM;
         pist_pkg::ST_TERM: st_in = pist_pkg::ST_TERMH;
         pist_pkg::ST_TERMH: begin
            if (j_ff == 2'd2) begin
               st_in = pist_pkg::ST_NEXT;
            end else begin
               j_in = j_ff + 2'd1;
               st_in = pist_pkg::ST_MINOR;
            end
         end
         pist_pkg::ST_NEXT: begin
            j_in = '0;
            if (k_ff == 3'd4) begin
               st_in = pist_pkg::ST_DONE;
            end else begin
               k_in = k_ff + 3'd1;
               st_in = pist_pkg::ST_MINOR;
            end
         end
         pist_pkg::ST_TRI: st_in = pist_pkg::ST_TRIC;
         pist_pkg::ST_TRIC: st_in = pist_pkg::ST_DONE;
         pist_pkg::ST_DONE: if (rsp_tready) st_in = pist_pkg::ST_IDLE;
         default: st_in = pist_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      job_ready = st_ff == pist_pkg::ST_IDLE;
      rsp_tvalid = st_ff == pist_pkg::ST_DONE;
      rsp_tdata = {7'd0, res_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= pist_pkg::ST_IDLE;
         k_ff <= '0;
         j_ff <= '0;
      end else begin
         st_ff <= st_in;
         k_ff <= k_in;
         j_ff <= j_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      case (st_ff)
         pist_pkg::ST_IDLE: begin
            job_ff <= job;
            acc_ff <= '0;
            ge_ff <= 1'b1;
            le_ff <= 1'b1;
         end
         pist_pkg::ST_MINOR: minor_ff <= minor_c;
         pist_pkg::ST_TERM: acc_ff <= acc_nx;
         pist_pkg::ST_TERMH: begin
            if (j_ff == 2'd2) begin
               if (det < -tol_w) ge_ff <= 1'b0;
               if (det > tol_w) le_ff <= 1'b0;
               acc_ff <= '0;
            end else begin
               acc_ff <= acc_nx;
            end
         end
         pist_pkg::ST_NEXT: res_ff <= ge_ff || le_ff;
         pist_pkg::ST_TRI: begin
            ns_ff <= ns_c;
            nt_ff <= nt_c;
            den_ff <= den_c;
         end
         pist_pkg::ST_TRIC: res_ff <= tri_ok;
         default: ;
      endcase
   end
endmodule

[src/point_in_simplex_test_top.sv]
// Throughput: one word per cycle; a trigger word waits only while the job queue is full.
// Back end: a triangle runs the TRI and TRIC steps; a tetrahedron is 5 determinants
// x 3 cofactors x 3 steps (minor, low and high term half) plus a NEXT step per det.
// A two-entry job queue lets loading continue while a test runs.
// Reset (synchronous, active high) clears the stores to zero, mode to 3D, tolerance to 1.
module point_in_simplex_test_top (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [79:0] req_tdata,  // coord_x[23:0], coord_y[47:24], coord_z[71:48]
   input  logic [2:0] req_tuser,   // role
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [7:0] rsp_tdata,   // inside_res[0]
   input  logic csr_valid,
   output logic csr_ready,
   input  logic csr_index,
   input  logic [39:0] csr_data
);
   logic mode_ff;
   logic [pist_pkg::TolBits-1:0] tol_ff;
   logic fj_valid, fj_ready, bj_valid, bj_ready;
   pist_pkg::job_type fj, bj;

   // configuration registers
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b1;
         tol_ff <= 40'd1;
      end else if (csr_valid) begin
         if (csr_index == pist_pkg::CsrMode) mode_ff <= csr_data[0];
         else tol_ff <= csr_data;
      end
   end

   pist_front u_front (
      .clock, .reset, .req_tvalid, .req_tready,
      .role(req_tuser), .cx(req_tdata[23:0]), .cy(req_tdata[47:24]),
      .cz(req_tdata[71:48]), .three_d(mode_ff), .tol(tol_ff),
      .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
   );

   pist_queue u_queue (
      .clock, .reset, .in_valid(fj_valid), .in_ready(fj_ready), .in_job(fj),
      .out_valid(bj_valid), .out_ready(bj_ready), .out_job(bj)
   );

   pist_back u_back (
      .clock, .reset, .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
      .rsp_tvalid, .rsp_tready, .rsp_tdata
   );
endmodule

[src/pist_checker.sv]
module pist_checker (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [7:0] rsp_tdata
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word dropped or changed while stalled");
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:1] == 7'd0)
      else $error("result padding not zero");
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result after reset");
   a_no_back2back: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready |=> !rsp_tvalid)
      else $error("results closer than the back end allows");
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid)
      else $error("input word withdrawn while stalled");
endmodule

bind point_in_simplex_test_top pist_checker u_pist_checker (
   .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready, .rsp_tdata
);

[sim/tb_point_in_simplex_test_top.sv]
module tb_point_in_simplex_test_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [pist_pkg::RoleBits-1:0] RoleV0 = 3'd1;
   localparam logic [pist_pkg::RoleBits-1:0] RoleV1 = 3'd2;
   localparam int ItemsPerPhase = 225;
   localparam int NumPhases = 8;
   localparam int DrainCycles = 40;
   localparam int StallLimit = 5000;
   localparam int CoordMax = 8388607;
   localparam int CoordMin = -8388608;
   localparam int NoCheck = -1;

   typedef logic signed [127:0] wide_type;

   // one row of the directed table
   typedef struct {
      logic three_d;
      logic [pist_pkg::RoleBits-1:0] role;
      int x;
      int y;
      int z;
      int want;  // NoCheck: use the predictor
   } dir_row_type;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [79:0] req_tdata;  // coord_x[23:0], coord_y[47:24], coord_z[71:48]
   logic [2:0] req_tuser;   // role
   logic rsp_tvalid;
   logic rsp_tready;
   logic [7:0] rsp_tdata;   // inside_res[0]
   logic csr_valid;
   logic csr_ready;
   logic csr_index;
   logic [39:0] csr_data;

   // predictor state
   pist_pkg::coord_type pnt_st [3];
   pist_pkg::coord_type vtx_st [12];
   logic mode_st;
   logic [pist_pkg::TolBits-1:0] tol_st;

   bit inside_q [$];
   int typed_want;
   int err_cnt;
   int stall_cnt;
   int word_cnt;
   int hit_cnt;
   int rsp_cnt;
   int idle_pct;
   bit send_idle;
   bit recv_idle;
   logic cur_mode;

   dir_row_type dir_tab [] = '{
      // after reset: all-zero stores, 3D, every determinant zero
      '{1'b1, pist_pkg::RoleV3, 0, 0, 0, 1},
      '{1'b1, 3'd5, CoordMax, CoordMax, CoordMax, NoCheck},
      '{1'b1, 3'd6, 1, 2, 3, NoCheck},
      '{1'b1, 3'd7, CoordMin, CoordMin, CoordMin, NoCheck},
      '{1'b1, pist_pkg::RolePoint, 16384, 16384, 16384, NoCheck},
      '{1'b1, RoleV0, 0, 0, 0, NoCheck},
      '{1'b1, RoleV1, 65536, 0, 0, NoCheck},
      '{1'b1, pist_pkg::RoleV2, 0, 65536, 0, NoCheck},
      '{1'b1, pist_pkg::RoleV3, 0, 0, 65536, NoCheck},
      '{1'b1, RoleV0, CoordMax, CoordMax, CoordMax, NoCheck},
      '{1'b1, RoleV1, CoordMin, CoordMax, CoordMin, NoCheck},
      '{1'b1, pist_pkg::RoleV2, CoordMax, CoordMin, CoordMin, NoCheck},
      '{1'b1, pist_pkg::RoleV3, CoordMin, CoordMin, CoordMax, NoCheck},
      // triangle mode: all vertices collapsed to the origin is degenerate
      '{1'b0, RoleV0, 0, 0, 0, NoCheck},
      '{1'b0, RoleV1, 0, 0, 0, NoCheck},
      '{1'b0, pist_pkg::RoleV2, 0, 0, 0, 0},
      '{1'b0, pist_pkg::RolePoint, 16384, 16384, CoordMin, NoCheck},
      '{1'b0, RoleV1, 65536, 0, 0, NoCheck},
      '{1'b0, pist_pkg::RoleV2, 0, 65536, 0, 1},
      // vertex 3 in triangle mode only stores
      '{1'b0, pist_pkg::RoleV3, 5, 5, 5, NoCheck},
      '{1'b0, pist_pkg::RolePoint, 65536, 0, 0, NoCheck},
      '{1'b0, pist_pkg::RoleV2, 0, 65536, CoordMax, 1},
      '{1'b0, pist_pkg::RolePoint, CoordMax, CoordMin, 0, NoCheck},
      '{1'b0, RoleV0, CoordMin, CoordMin, 0, NoCheck},
      '{1'b0, pist_pkg::RoleV2, CoordMax, CoordMax, 0, NoCheck}
   };

   point_in_simplex_test_top u_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // negated 3x3 determinant of the edge vectors from row 0
   function automatic wide_type tet_det(pist_pkg::coord_type [3:0][2:0] r);
      wide_type a [3];
      wide_type b [3];
      wide_type c [3];
      wide_type t;
      for (int i = 0; i < 3; i++) begin
         a[i] = wide_type'(r[1][i]) - wide_type'(r[0][i]);
         b[i] = wide_type'(r[2][i]) - wide_type'(r[0][i]);
         c[i] = wide_type'(r[3][i]) - wide_type'(r[0][i]);
      end
      t = a[0] * (b[1] * c[2] - b[2] * c[1]);
      t = t - a[1] * (b[0] * c[2] - b[2] * c[0]);
      t = t + a[2] * (b[0] * c[1] - b[1] * c[0]);
      return -t;
   endfunction

   function automatic bit tetra_inside();
      pist_pkg::coord_type [3:0][2:0] rows;
      wide_type tol;
      wide_type d;
      bit all_ge;
      bit all_le;
      tol = wide_type'({88'd0, tol_st});
      all_ge = 1'b1;
      all_le = 1'b1;
      for (int k = 0; k < 5; k++) begin
         for (int v = 0; v < 4; v++)
            for (int i = 0; i < 3; i++)
               rows[v][i] = (k == v + 1) ? pnt_st[i] : vtx_st[3 * v + i];
         d = tet_det(rows);
         if (d < -tol) all_ge = 1'b0;
         if (d > tol) all_le = 1'b0;
      end
      return all_ge || all_le;
   endfunction

   // barycentric test without division; zero denominator is outside
   function automatic bit tri_inside();
      wide_type x01, y01, x02, y02, x0p, y0p, ns, nt, den;
      x01 = wide_type'(vtx_st[0]) - wide_type'(vtx_st[3]);
      y01 = wide_type'(vtx_st[1]) - wide_type'(vtx_st[4]);
      x02 = wide_type'(vtx_st[0]) - wide_type'(vtx_st[6]);
      y02 = wide_type'(vtx_st[1]) - wide_type'(vtx_st[7]);
      x0p = wide_type'(vtx_st[0]) - wide_type'(pnt_st[0]);
      y0p = wide_type'(vtx_st[1]) - wide_type'(pnt_st[1]);
      ns = x0p * y02 - x02 * y0p;
      nt = x01 * y0p - x0p * y01;
      den = x01 * y02 - x02 * y01;
      if (den == 0) return 1'b0;
      if (den < 0) begin
         ns = -ns;
         nt = -nt;
         den = -den;
      end
      return ns >= 0 && ns <= den && nt >= 0 && nt <= den && ns + nt <= den;
   endfunction

   task automatic report(input string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      err_cnt++;
   endtask

   // predictor and checker, both on the rising edge
   always @(posedge clock) begin
      bit hit;
      logic [pist_pkg::RoleBits-1:0] role;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            if (csr_index == pist_pkg::CsrMode) mode_st = csr_data[0];
            else if (csr_index == pist_pkg::CsrTol) tol_st = csr_data;
         end
         if (req_tvalid && req_tready) begin
            role = req_tuser;
            word_cnt++;
            if (role == pist_pkg::RolePoint) begin
               for (int i = 0; i < 3; i++) pnt_st[i] = req_tdata[24 * i +: 24];
            end else if (role <= pist_pkg::RoleV3) begin
               for (int i = 0; i < 3; i++)
                  vtx_st[3 * (role - 1) + i] = req_tdata[24 * i +: 24];
               if ((!mode_st && role == pist_pkg::RoleV2) ||
                   (mode_st && role == pist_pkg::RoleV3)) begin
                  hit = mode_st ? tetra_inside() : tri_inside();
                  if (typed_want != NoCheck && hit != typed_want[0])
                     report($sformatf("predictor gives %0d, table gives %0d",
                                      hit, typed_want));
                  inside_q.push_back(typed_want != NoCheck ? typed_want[0] : hit);
               end
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            rsp_cnt++;
            if (inside_q.size() == 0) begin
               report("result word with nothing expected");
            end else begin
               hit = inside_q.pop_front();
               hit_cnt += hit;
               if (rsp_tdata[0] != hit)
                  report($sformatf("inside_res %0d, expected %0d", rsp_tdata[0], hit));
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         stall_cnt <= 0;
      end else if (stall_cnt >= StallLimit) begin
         $display("Watchdog: no handshake for %0d cycles", StallLimit);
         $display("Verification failed");
         $finish;
      end else begin
         stall_cnt <= stall_cnt + 1;
      end
   end

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_tready <= recv_idle ? ($urandom_range(99) >= idle_pct) : 1'b1;
   end

   // send_word, drain and write_csr start and end at a falling edge
   task automatic send_word(input logic [pist_pkg::RoleBits-1:0] role,
                            input pist_pkg::coord_type x, input pist_pkg::coord_type y,
                            input pist_pkg::coord_type z, input int want);
      while (send_idle && $urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= role;
      req_tdata <= {8'd0, z, y, x};
      typed_want = want;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (inside_q.size() != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [39:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      if (idx == pist_pkg::CsrMode) cur_mode = val[0];
   endtask

   function automatic pist_pkg::coord_type rand_coord();
      int k;
      k = $urandom_range(9);
      if (k == 0) return pist_pkg::coord_type'(CoordMax);
      if (k == 1) return pist_pkg::coord_type'(CoordMin);
      if (k < 6) return pist_pkg::coord_type'($urandom_range(8 * 65536) - 4 * 65536);
      return pist_pkg::coord_type'($urandom);
   endfunction

   // stimulus
   initial begin
      int sent;
      int nv;
      logic [39:0] tol;
      pist_pkg::coord_type v0 [3];
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_index = pist_pkg::CsrMode;
      csr_data = '0;
      send_idle = 1'b0;
      recv_idle = 1'b0;
      idle_pct = 70;
      typed_want = NoCheck;
      err_cnt = 0;
      word_cnt = 0;
      hit_cnt = 0;
      rsp_cnt = 0;
      cur_mode = 1'b1;
      mode_st = 1'b1;
      tol_st = 40'd1;
      foreach (pnt_st[i]) pnt_st[i] = '0;
      foreach (vtx_st[i]) vtx_st[i] = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table
      foreach (dir_tab[i]) begin
         if (dir_tab[i].three_d != cur_mode) begin
            drain();
            write_csr(pist_pkg::CsrMode, {39'd0, dir_tab[i].three_d});
         end
         send_word(dir_tab[i].role, pist_pkg::coord_type'(dir_tab[i].x),
                   pist_pkg::coord_type'(dir_tab[i].y),
                   pist_pkg::coord_type'(dir_tab[i].z), dir_tab[i].want);
      end

      // random phases: each one drains fully before its register writes
      for (int p = 0; p < NumPhases; p++) begin
         drain();
         send_idle = (p % 4 == 1) || (p % 4 == 3);
         recv_idle = (p % 4 == 2) || (p % 4 == 3);
         idle_pct = (p % 4 == 3) ? 36 : 70;
         case (p)
            0: tol = 40'd1;
            2: tol = 40'd0;
            4: tol = {40{1'b1}};
            5: tol = 40'({$urandom, $urandom});
            default: tol = 40'($urandom_range(1 << 20));
         endcase
         write_csr(pist_pkg::CsrTol, tol);
         write_csr(pist_pkg::CsrMode, {39'd0, !(p == 1 || p == 3 || p == 6)});
         sent = 0;
         while (sent < ItemsPerPhase) begin
            int r;
            r = $urandom_range(99);
            if (r < 5) begin
               // unused roles are ignored
               send_word(3'($urandom_range(5, 7)), rand_coord(), rand_coord(), rand_coord(),
                         NoCheck);
            end else if (r < 12) begin
               // a stray vertex, or vertex 3 in triangle mode
               send_word(cur_mode ? 3'($urandom_range(1, 3)) : pist_pkg::RoleV3,
                         rand_coord(), rand_coord(), rand_coord(), NoCheck);
               sent++;
            end else if (r < 20) begin
               send_word(pist_pkg::RolePoint, rand_coord(), rand_coord(), rand_coord(),
                         NoCheck);
               sent++;
            end else begin
               if ($urandom_range(1)) begin
                  send_word(pist_pkg::RolePoint, rand_coord(), rand_coord(), rand_coord(),
                            NoCheck);
                  sent++;
               end
               nv = cur_mode ? 4 : 3;
               foreach (v0[i]) v0[i] = rand_coord();
               for (int v = 0; v < nv; v++) begin
                  // occasionally repeat vertex 0 for a flat element
                  if (v == 0 || $urandom_range(99) < 10)
                     send_word(3'(v + 1), v0[0], v0[1], v0[2], NoCheck);
                  else
                     send_word(3'(v + 1), rand_coord(), rand_coord(), rand_coord(), NoCheck);
                  sent++;
               end
            end
         end
      end

      drain();
      $display("Summary: %0d input words, %0d results (%0d inside) over %0d phases",
               word_cnt, rsp_cnt, hit_cnt, NumPhases);
      $display("Covered both modes, tolerance 0/1/max/random, all idle patterns");
      if (err_cnt == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
